FILE: rtl/rmst_pkg.sv
// Shared constants, widths and the controller state type for the range-minimum segment tree.
// No dependencies; every other SystemVerilog file in the project uses this package.
`default_nettype none

package rmst_pkg;

  // Tree geometry: LEAVES elements, node n of the bottom-up tree lives in row n/2.
  localparam int LEAVES = 1024;
  localparam int LEAF_W = $clog2(LEAVES);
  localparam int NODE_W = LEAF_W + 1;
  localparam int SPAN_W = NODE_W + 1;
  localparam int ROWS   = LEAVES;

  // Fixed field widths of the stream and register interface.
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int USE_W  = (CNT_W > NODE_W) ? CNT_W : NODE_W;
  localparam int IN_W   = 56;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7fffffff;
  localparam logic [CNT_W-1:0]        CNT_RESET = 11'd1024;

  // Request kinds carried in tuser.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Register index, taken from paddr above the byte offset.
  localparam logic [ADDR_W-3:0] REG_LEAF_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/range_min_segment_tree.sv
// Range-minimum segment tree with point update, held in a synchronous paired-node memory.
// Depends on rmst_pkg for widths, constants and the controller state type.
// Update: a read of the leaf's row, then one tree level per cycle up to the root.
// Query: the walk climbs the tree from both edges until they meet, then offers the result.
// A new request is taken only once the previous one is through, and a stalled result holds
// the port longer; an ignored update or an empty query frees it without a tree walk.
// After reset a clearing pass over all ROWS rows fills the tree with 2147483647;
// no request is taken during it, register writes are taken as ever.
`default_nettype none

module range_min_segment_tree (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Requests.
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // From bit 0: first[9:0], last[19:10], value[51:20], zero padding[55:52].
  input  wire logic [rmst_pkg::IN_W-1:0]     s_axis_tdata,
  // Bit 0: action (0 update, 1 query).
  input  wire logic                          s_axis_tuser,
  // Results.
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // Bits 31:0: minimum.
  output      logic [rmst_pkg::VAL_W-1:0]    m_axis_tdata,
  // Register port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rmst_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rmst_pkg::DATA_W-1:0]   pwdata,
  output      logic [rmst_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready
);

  // Each memory row holds a sibling pair: the even node in the low half and the
  // odd node in the high half. Node 1, the root, sits in the high half of row 0.
  logic [2*rmst_pkg::VAL_W-1:0] tree_mem [rmst_pkg::ROWS];
  logic [2*rmst_pkg::VAL_W-1:0] rdata_a;
  logic [2*rmst_pkg::VAL_W-1:0] rdata_b;
  logic [2*rmst_pkg::VAL_W-1:0] wdata;
  logic [2*rmst_pkg::VAL_W-1:0] row_mod;
  logic [rmst_pkg::LEAF_W-1:0]  raddr_a;
  logic [rmst_pkg::LEAF_W-1:0]  raddr_b;
  logic [rmst_pkg::LEAF_W-1:0]  waddr;
  logic                         mem_we;

  rmst_pkg::state_t state, state_next;

  logic [rmst_pkg::CNT_W-1:0]        leaf_count;
  logic [rmst_pkg::LEAF_W-1:0]       clr_row, clr_row_next;
  logic [rmst_pkg::NODE_W-1:0]       node, node_next;
  logic signed [rmst_pkg::VAL_W-1:0] upd_val, upd_val_next;
  logic [rmst_pkg::SPAN_W-1:0]       lo, lo_next;
  logic [rmst_pkg::SPAN_W-1:0]       hi, hi_next;
  logic [rmst_pkg::SPAN_W-1:0]       hi_dec;
  logic                              take_lo, take_lo_next;
  logic                              take_hi, take_hi_next;
  logic signed [rmst_pkg::VAL_W-1:0] best, best_next;
  logic signed [rmst_pkg::VAL_W-1:0] best_lo;
  logic signed [rmst_pkg::VAL_W-1:0] best_fold;
  logic                              out_valid_next;
  logic [rmst_pkg::VAL_W-1:0]        out_data_next;

  logic [rmst_pkg::POS_W-1:0]        in_first;
  logic [rmst_pkg::POS_W-1:0]        in_last;
  logic signed [rmst_pkg::VAL_W-1:0] in_value;
  logic [rmst_pkg::USE_W-1:0]        used;
  logic [rmst_pkg::USE_W-1:0]        first_u;
  logic [rmst_pkg::USE_W-1:0]        last_u;
  logic [rmst_pkg::USE_W-1:0]        last_c;
  logic                              upd_ok;
  logic                              qry_empty;
  logic                              accept;
  logic                              out_free;
  logic                              cfg_write;
  logic signed [rmst_pkg::VAL_W-1:0] lo_val;
  logic signed [rmst_pkg::VAL_W-1:0] hi_val;
  logic signed [rmst_pkg::VAL_W-1:0] mod_even;
  logic signed [rmst_pkg::VAL_W-1:0] mod_odd;

  // Request fields.
  assign in_first = s_axis_tdata[rmst_pkg::POS_W-1:0];
  assign in_last  = s_axis_tdata[2*rmst_pkg::POS_W-1:rmst_pkg::POS_W];
  assign in_value = signed'(s_axis_tdata[2*rmst_pkg::POS_W+rmst_pkg::VAL_W-1:2*rmst_pkg::POS_W]);

  assign s_axis_tready = (state == rmst_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // The number of elements in use: a count of zero behaves as one, and a
  // count beyond the tree behaves as the full tree.
  always_comb begin
    if (leaf_count == '0) begin
      used = rmst_pkg::USE_W'(1);
    end else if (rmst_pkg::USE_W'(leaf_count) > rmst_pkg::USE_W'(rmst_pkg::LEAVES)) begin
      used = rmst_pkg::USE_W'(rmst_pkg::LEAVES);
    end else begin
      used = rmst_pkg::USE_W'(leaf_count);
    end
  end

  // Clip the query to the elements in use; an inverted or out-of-use range is empty.
  assign first_u   = rmst_pkg::USE_W'(in_first);
  assign last_u    = rmst_pkg::USE_W'(in_last);
  assign last_c    = (last_u >= used) ? used - rmst_pkg::USE_W'(1) : last_u;
  assign upd_ok    = first_u < used;
  assign qry_empty = (first_u >= used) || (first_u > last_c);

  // Port A reads the odd half for the left edge of a query, port B the even
  // half for the right edge; an update walks its path through port A.
  assign lo_val = signed'(rdata_a[2*rmst_pkg::VAL_W-1:rmst_pkg::VAL_W]);
  assign hi_val = signed'(rdata_b[rmst_pkg::VAL_W-1:0]);
  assign hi_dec = hi - rmst_pkg::SPAN_W'(1);

  // Fold the nodes read in the previous cycle into the running minimum.
  assign best_lo   = (take_lo && (lo_val < best)) ? lo_val : best;
  assign best_fold = (take_hi && (hi_val < best_lo)) ? hi_val : best_lo;

  // Update step: replace this node's half of the row and form the parent's minimum.
  always_comb begin
    row_mod = rdata_a;
    if (node[0]) begin
      row_mod[2*rmst_pkg::VAL_W-1:rmst_pkg::VAL_W] = upd_val;
    end else begin
      row_mod[rmst_pkg::VAL_W-1:0] = upd_val;
    end
  end
  assign mod_even = signed'(row_mod[rmst_pkg::VAL_W-1:0]);
  assign mod_odd  = signed'(row_mod[2*rmst_pkg::VAL_W-1:rmst_pkg::VAL_W]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rmst_pkg::ST_CLEAR: begin
        if (clr_row == rmst_pkg::LEAF_W'(rmst_pkg::ROWS - 1)) begin
          state_next = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == rmst_pkg::ACT_QUERY) begin
            state_next = qry_empty ? rmst_pkg::ST_FIN : rmst_pkg::ST_QRY;
          end else if (upd_ok) begin
            state_next = rmst_pkg::ST_UPD_RD;
          end
        end
      end
      rmst_pkg::ST_UPD_RD: begin
        state_next = rmst_pkg::ST_UPD_WR;
      end
      rmst_pkg::ST_UPD_WR: begin
        if (node == rmst_pkg::NODE_W'(1)) begin
          state_next = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_QRY: begin
        if (lo >= hi) begin
          state_next = rmst_pkg::ST_FIN;
        end
      end
      rmst_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = rmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmst_pkg::ST_CLEAR;
      end
    endcase
  end

  // Memory ports and datapath.
  always_comb begin
    mem_we         = 1'b0;
    waddr          = node[rmst_pkg::NODE_W-1:1];
    wdata          = row_mod;
    raddr_a        = lo[rmst_pkg::NODE_W-1:1];
    raddr_b        = hi_dec[rmst_pkg::NODE_W-1:1];
    clr_row_next   = clr_row;
    node_next      = node;
    upd_val_next   = upd_val;
    lo_next        = lo;
    hi_next        = hi;
    take_lo_next   = 1'b0;
    take_hi_next   = 1'b0;
    best_next      = best_fold;
    out_valid_next = m_axis_tvalid;
    out_data_next  = m_axis_tdata;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      rmst_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        waddr        = clr_row;
        wdata        = {rmst_pkg::TOP_VALUE, rmst_pkg::TOP_VALUE};
        clr_row_next = clr_row + rmst_pkg::LEAF_W'(1);
      end
      rmst_pkg::ST_IDLE: begin
        if (accept) begin
          node_next    = rmst_pkg::NODE_W'(rmst_pkg::LEAVES) + rmst_pkg::NODE_W'(in_first);
          upd_val_next = in_value;
          lo_next      = rmst_pkg::SPAN_W'(rmst_pkg::LEAVES) + rmst_pkg::SPAN_W'(first_u);
          hi_next      = rmst_pkg::SPAN_W'(rmst_pkg::LEAVES) + rmst_pkg::SPAN_W'(last_c)
                         + rmst_pkg::SPAN_W'(1);
          best_next    = rmst_pkg::TOP_VALUE;
        end
      end
      rmst_pkg::ST_UPD_RD: begin
        raddr_a = node[rmst_pkg::NODE_W-1:1];
      end
      rmst_pkg::ST_UPD_WR: begin
        // Write this level back and fetch the parent's row in the same cycle; the two rows differ
        // below the root, and the read at the root is not used, so no forwarding is needed.
        mem_we       = 1'b1;
        upd_val_next = (mod_even < mod_odd) ? mod_even : mod_odd;
        node_next    = node >> 1;
        raddr_a      = rmst_pkg::LEAF_W'(node >> 2);
      end
      rmst_pkg::ST_QRY: begin
        if (lo < hi) begin
          take_lo_next = lo[0];
          take_hi_next = hi[0];
          lo_next      = (lo + rmst_pkg::SPAN_W'(lo[0])) >> 1;
          hi_next      = (hi - rmst_pkg::SPAN_W'(hi[0])) >> 1;
        end
      end
      rmst_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = best;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Tree memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[waddr] <= wdata;
    end
    rdata_a <= tree_mem[raddr_a];
    rdata_b <= tree_mem[raddr_b];
  end

  // Register port.
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[rmst_pkg::ADDR_W-1:2] == rmst_pkg::REG_LEAF_COUNT);
  assign pready    = 1'b1;
  assign prdata    = (paddr[rmst_pkg::ADDR_W-1:2] == rmst_pkg::REG_LEAF_COUNT)
                     ? rmst_pkg::DATA_W'(leaf_count) : '0;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rmst_pkg::ST_CLEAR;
      clr_row       <= '0;
      take_lo       <= 1'b0;
      take_hi       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      leaf_count    <= rmst_pkg::CNT_RESET;
    end else begin
      state         <= state_next;
      clr_row       <= clr_row_next;
      take_lo       <= take_lo_next;
      take_hi       <= take_hi_next;
      m_axis_tvalid <= out_valid_next;
      if (cfg_write) begin
        leaf_count <= pwdata[rmst_pkg::CNT_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    node         <= node_next;
    upd_val      <= upd_val_next;
    lo           <= lo_next;
    hi           <= hi_next;
    best         <= best_next;
    m_axis_tdata <= out_data_next;
  end

endmodule

`default_nettype wire

FILE: rtl/rmst_checker.sv
// Port-level checks for range_min_segment_tree, attached to it by a bind statement.
// Depends on rmst_pkg for widths and request kinds.
`default_nettype none

module rmst_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [rmst_pkg::VAL_W-1:0]    m_axis_tdata
);

  // The clearing pass follows every reset, so no request is taken just after it.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request accepted during the clearing pass");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A query keeps the block busy until its result is formed.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmst_pkg::ACT_QUERY)
    |=> !s_axis_tready)
    else $error("request taken while a query is in flight");

  // An update never produces a result.
  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmst_pkg::ACT_UPDATE)
    && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result produced by an update");

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for range_min_segment_tree: point updates and range-minimum queries
// over the request and result streams, with the element count set through the register port.
// Depends on rmst_pkg and the range_min_segment_tree RTL only.
`timescale 1ns / 1ps

module tb;

  // Enough cycles for an update or query to finish inside the block after the last result.
  localparam int SETTLE_CYCLES = 30;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // From bit 0: first[9:0], last[19:10], value[51:20], zero padding[55:52].
  logic [rmst_pkg::IN_W-1:0]     s_axis_tdata;
  // Bit 0: action (0 update, 1 query).
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // Bits 31:0: minimum.
  logic [rmst_pkg::VAL_W-1:0]    m_axis_tdata;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rmst_pkg::ADDR_W-1:0]   paddr;
  logic [rmst_pkg::DATA_W-1:0]   pwdata;
  logic [rmst_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  range_min_segment_tree dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The predictor keeps the plain element array rather than a tree: the minimum over a range
  // of the array is, by definition, what the block's tree walk must produce.
  logic signed [rmst_pkg::VAL_W-1:0] element_value [0:rmst_pkg::LEAVES-1];
  logic [rmst_pkg::CNT_W-1:0]        leaf_count_reg;
  logic signed [rmst_pkg::VAL_W-1:0] expected_minima [$];
  int                                error_count = 0;

  // Idle rates in percent; the results side is driven from its own process below.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that hangs is a failure in its own right.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // A count of zero behaves as one element, anything above the tree size as the full tree.
  function automatic int unsigned elements_in_use();
    if (leaf_count_reg == '0) return 1;
    if (leaf_count_reg > rmst_pkg::LEAVES) return rmst_pkg::LEAVES;
    return 32'(leaf_count_reg);
  endfunction

  // Least element over lo..hi once hi is clipped to the elements in use. A start outside
  // the elements in use, or a start above the clipped end, leaves the top value.
  function automatic logic signed [rmst_pkg::VAL_W-1:0] range_least(
      input logic [rmst_pkg::POS_W-1:0] lo, input logic [rmst_pkg::POS_W-1:0] hi);
    int unsigned                       used;
    int unsigned                       top;
    logic signed [rmst_pkg::VAL_W-1:0] best;
    used = elements_in_use();
    top  = 32'(hi);
    best = rmst_pkg::TOP_VALUE;
    if (top >= used) top = used - 1;
    if (lo < used && lo <= top) begin
      for (int unsigned p = 32'(lo); p <= top; p++) begin
        if (element_value[p] < best) best = element_value[p];
      end
    end
    return best;
  endfunction

  // Applies one accepted request to the predicted state. Updates beyond the elements in use
  // are dropped; every query leaves exactly one expected minimum behind.
  task automatic predict_request(input logic act, input logic [rmst_pkg::POS_W-1:0] lo,
                                 input logic [rmst_pkg::POS_W-1:0] hi,
                                 input logic signed [rmst_pkg::VAL_W-1:0] v);
    if (act == rmst_pkg::ACT_UPDATE) begin
      if (lo < elements_in_use()) element_value[lo] = v;
    end else begin
      expected_minima.push_back(range_least(lo, hi));
    end
  endtask

  // Offers one request and returns at the edge where it is taken. tvalid is left high so that
  // back-to-back requests do not drop it for a cycle; idling and draining lower it.
  task automatic send_request(input logic act, input logic [rmst_pkg::POS_W-1:0] lo,
                              input logic [rmst_pkg::POS_W-1:0] hi,
                              input logic signed [rmst_pkg::VAL_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, v, hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(act, lo, hi, v);
  endtask

  // Holds the sender back until every query so far has been answered. At least one edge
  // passes, so tvalid is never lowered and raised again within the same step.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_minima.size() != 0);
  endtask

  // An update gives no result, so after the last answer the block may still be busy with one.
  task automatic wait_until_idle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the element count through a setup and an access cycle, then reads it back.
  task automatic write_leaf_count(input logic [rmst_pkg::CNT_W-1:0] count);
    logic [rmst_pkg::DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rmst_pkg::REG_LEAF_COUNT, 2'b00};
    pwdata  <= rmst_pkg::DATA_W'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    leaf_count_reg = count;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== rmst_pkg::DATA_W'(count))
      report_mismatch($sformatf("leaf_count read back %0d, wrote %0d", readback, count));
  endtask

  // Extremes of position and value with every element in use, on a freshly cleared tree.
  task automatic test_extremes();
    send_request(rmst_pkg::ACT_QUERY, 10'd0, 10'd1023, '0);
    send_request(rmst_pkg::ACT_UPDATE, 10'd0, 10'd0, 32'sh80000000);
    send_request(rmst_pkg::ACT_UPDATE, 10'd1023, 10'd0, rmst_pkg::TOP_VALUE);
    send_request(rmst_pkg::ACT_UPDATE, 10'd512, 10'd0, 32'sd0);
    send_request(rmst_pkg::ACT_UPDATE, 10'd511, 10'd0, -32'sd1);
    send_request(rmst_pkg::ACT_QUERY, 10'd0, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd1, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd513, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd1023, 10'd1023, '0);
    // A start above the end is an empty range.
    send_request(rmst_pkg::ACT_QUERY, 10'd600, 10'd100, '0);
  endtask

  // Counts of zero and above the tree size, updates and queries past the elements in use,
  // and elements that fall out of use and later come back.
  task automatic test_use_limits();
    wait_until_idle();
    write_leaf_count(11'd0);
    send_request(rmst_pkg::ACT_UPDATE, 10'd1, 10'd0, -32'sd5);
    send_request(rmst_pkg::ACT_QUERY, 10'd0, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd1, 10'd1, '0);
    wait_until_idle();
    write_leaf_count(11'd2047);
    send_request(rmst_pkg::ACT_QUERY, 10'd0, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd1023, 10'd1023, '0);
    wait_until_idle();
    write_leaf_count(11'd512);
    send_request(rmst_pkg::ACT_QUERY, 10'd511, 10'd1023, '0);
    send_request(rmst_pkg::ACT_QUERY, 10'd512, 10'd1023, '0);
    send_request(rmst_pkg::ACT_UPDATE, 10'd1023, 10'd0, -32'sd7);
    wait_until_idle();
    write_leaf_count(11'd1024);
    send_request(rmst_pkg::ACT_QUERY, 10'd1000, 10'd1023, '0);
  endtask

  function automatic logic signed [rmst_pkg::VAL_W-1:0] pick_value();
    logic signed [rmst_pkg::VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'sh80000000;
      1:       v = rmst_pkg::TOP_VALUE;
      2, 3, 4: begin
        // Small values make ties and near-ties common.
        v = $urandom_range(0, 200);
        v = v - 32'sd100;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // One random request shaped for the count in use: most positions and ranges fall inside
  // it, some anywhere in the field's range.
  task automatic send_random_request(input int unsigned used, input bit load);
    int unsigned lo;
    int unsigned hi;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (load || $urandom_range(0, 1) == 0) begin
      lo = (sel < 8) ? $urandom_range(0, used - 1) : $urandom_range(0, rmst_pkg::LEAVES - 1);
      send_request(rmst_pkg::ACT_UPDATE, lo[rmst_pkg::POS_W-1:0],
                   rmst_pkg::POS_W'($urandom), pick_value());
    end else begin
      if (sel < 4) begin
        lo = $urandom_range(0, used - 1);
        hi = $urandom_range(lo, used - 1);
      end else if (sel < 6) begin
        lo = $urandom_range(0, used - 1);
        hi = lo + $urandom_range(0, 15);
        if (hi > used - 1) hi = used - 1;
      end else if (sel < 7) begin
        lo = $urandom_range(0, used - 1);
        hi = lo;
      end else begin
        lo = $urandom_range(0, rmst_pkg::LEAVES - 1);
        hi = $urandom_range(0, rmst_pkg::LEAVES - 1);
      end
      send_request(rmst_pkg::ACT_QUERY, lo[rmst_pkg::POS_W-1:0], hi[rmst_pkg::POS_W-1:0],
                   rmst_pkg::VAL_W'($urandom));
    end
  endtask

  // One phase of random traffic under one element count: a burst of updates to load
  // contents, then mixed requests, with a full drain half way through.
  task automatic test_random_traffic(input logic [rmst_pkg::CNT_W-1:0] count,
                                     input int requests);
    int unsigned used;
    wait_until_idle();
    write_leaf_count(count);
    used = elements_in_use();
    for (int i = 0; i < requests; i++) begin
      if (i == requests / 2) wait_for_results();
      send_random_request(used, i < 20);
    end
  endtask

  // The results side stalls at random, cycle by cycle.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Every result taken is matched against the oldest outstanding query.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_minima.size() == 0) begin
        report_mismatch($sformatf("minimum %0d with no query outstanding",
                                  $signed(m_axis_tdata)));
      end else if ($signed(m_axis_tdata) !== expected_minima[0]) begin
        report_mismatch($sformatf("minimum %0d, predicted %0d",
                                  $signed(m_axis_tdata), expected_minima[0]));
        void'(expected_minima.pop_front());
      end else begin
        void'(expected_minima.pop_front());
      end
    end
  end

  initial begin
    logic [rmst_pkg::CNT_W-1:0] phase_count [0:7];
    int                         guard;

    phase_count = '{11'd1024, 11'd37, 11'd2047, 11'd0, 11'd1, 11'd700, 11'd513, 11'd1024};
    for (int p = 0; p < rmst_pkg::LEAVES; p++) element_value[p] = rmst_pkg::TOP_VALUE;
    leaf_count_reg = rmst_pkg::CNT_RESET;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rmst_pkg::ACT_UPDATE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed part runs without idling; the first request simply waits out the
    // clearing pass that follows reset.
    test_extremes();
    test_use_limits();

    // Sender idles less at first and the receiver stalls more, then the other way round,
    // then both run flat out.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        tx_idle_pct  = 25;
        rx_stall_pct = 55;
      end else if (ph < 6) begin
        tx_idle_pct  = 55;
        rx_stall_pct = 25;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      test_random_traffic(phase_count[ph], 250);
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (expected_minima.size() != 0 && guard < 100_000);
    if (expected_minima.size() != 0)
      report_mismatch($sformatf("%0d queries never answered", expected_minima.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rmst_pkg.sv
rtl/range_min_segment_tree.sv
rtl/rmst_checker.sv
verif/tb.sv
